/* hdl/nht_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package nht_pkg;

	// Table geometry.
	localparam int MAX_ENTRIES = 64;
	localparam int NAME_BYTES  = 8;
	localparam int SLOT_BIAS   = 23;
	localparam int SLOT_DEPTH  = 2 * MAX_ENTRIES + SLOT_BIAS;
	localparam int SLOT_W      = $clog2(SLOT_DEPTH);
	localparam int ENTRY_AW    = $clog2(MAX_ENTRIES);
	localparam int IDX_W       = 7;
	localparam int NAME_W      = 64;
	localparam int FUNC_W      = 2;
	localparam int STATUS_W    = 2;
	localparam int OUT_DATA_W  = 16;

	// ELF hash constants.
	localparam logic [31:0] HASH_TOP_MASK = 32'hf000_0000;
	localparam int          HASH_FOLD     = 24;
	localparam int          HASH_SHIFT    = 4;
	localparam int          HASH_W        = 28;
	localparam int          MOD_DIGITS    = HASH_W / HASH_SHIFT;

	// Operation codes.
	localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

	// Result status codes.
	localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

	// Result of the hash unit: a one-cycle done pulse and the home slot.
	typedef struct packed {
		logic              done;
		logic [SLOT_W-1:0] pos;
	} hash_res_t;

	// Zero every byte from the first NUL on and every byte beyond nbytes.
	function automatic logic [NAME_W-1:0] canon_name(input logic [NAME_W-1:0] key,
			input int unsigned nbytes);
		logic [NAME_W-1:0] r;
		logic              live;
		r    = '0;
		live = 1'b1;
		for (int unsigned i = 0; i < 8; i++) begin
			if (i >= nbytes || key[8*i +: 8] == 8'h00) begin
				live = 1'b0;
			end
			if (live) begin
				r[8*i +: 8] = key[8*i +: 8];
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

/* hdl/name_hash_table_linear_probe.sv */
`timescale 1ns / 1ps
`default_nettype none

// Clear, the unused code and an insert into a full table go straight to the result; other
// operations run the byte-serial hash over the name bytes before the first NUL and the
// modulo, then probe slots: an insert probe in ST_INS, a lookup probe through ST_LK_SLOT,
// ST_LK_NAME and ST_LK_CMP (ending at ST_LK_NAME if it meets an empty slot).
// Throughput: one operation at a time; the next transfer is taken once the result is registered.
// Reset is asynchronous: the table is empty, variable_count is 64, and slot valid bits clear.
module name_hash_table_linear_probe import nht_pkg::*; #(
	parameter int NAME_LEN = NAME_BYTES
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// Configuration: variable_count.
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [IDX_W-1:0]      cfg_data,
	// Requests.
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	input  wire logic [NAME_W-1:0]     s_axis_tdata,   // [63:0] name_key
	input  wire logic [FUNC_W-1:0]     s_axis_tuser,   // [1:0] func
	// Results.
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	output logic      [OUT_DATA_W-1:0] m_axis_tdata    // [6:0] entry_index, [8:7] status
);

	typedef enum logic [6:0] {
		ST_IDLE    = 7'b0000001,
		ST_HASH    = 7'b0000010,
		ST_INS     = 7'b0000100,
		ST_LK_SLOT = 7'b0001000,
		ST_LK_NAME = 7'b0010000,
		ST_LK_CMP  = 7'b0100000,
		ST_DONE    = 7'b1000000
	} state_t;

	state_t                state_q;
	logic [IDX_W-1:0]      cfg_q;
	logic [IDX_W-1:0]      used_q;
	logic [SLOT_DEPTH-1:0] valid_q;
	logic [FUNC_W-1:0]     func_q;
	logic [NAME_W-1:0]     name_q;
	logic [SLOT_W-1:0]     pos_q;
	logic [SLOT_W-1:0]     probes_q;
	logic [IDX_W-1:0]      entry_q;
	logic [IDX_W-1:0]      res_idx_q;
	logic [STATUS_W-1:0]   res_st_q;
	logic                  out_valid_q;
	logic [IDX_W-1:0]      out_idx_q;
	logic [STATUS_W-1:0]   out_st_q;

	logic [IDX_W-1:0]      n_eff;
	logic [SLOT_W-1:0]     slots;
	logic [NAME_W-1:0]     in_name;
	logic                  in_xfer;
	logic                  cfg_xfer;
	logic                  hash_start;
	hash_res_t             hash_res;
	logic [SLOT_W-1:0]     pos_next;
	logic                  last_probe;
	logic                  ins_hit;
	logic                  out_free;

	logic                  slot_we;
	logic [IDX_W-1:0]      slot_rdata;
	logic                  name_we;
	logic [ENTRY_AW-1:0]   name_raddr;
	logic [NAME_W-1:0]     name_rdata;
	logic [IDX_W-1:0]      entry_m1;

	// Effective count and slot count.
	always_comb begin
		if (cfg_q == '0) begin
			n_eff = IDX_W'(1);
		end else if (cfg_q > IDX_W'(MAX_ENTRIES)) begin
			n_eff = IDX_W'(MAX_ENTRIES);
		end else begin
			n_eff = cfg_q;
		end
		slots = {n_eff, 1'b0} + SLOT_W'(SLOT_BIAS);
	end

	// A pending configuration write goes first; requests wait for it.
	assign in_name       = canon_name(s_axis_tdata, NAME_LEN);
	assign s_axis_tready = (state_q == ST_IDLE) && !cfg_valid;
	assign cfg_ready     = (state_q == ST_IDLE);
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign cfg_xfer      = cfg_valid && cfg_ready;
	assign hash_start    = in_xfer && (s_axis_tuser == FUNC_LOOKUP ||
			(s_axis_tuser == FUNC_INSERT && used_q < n_eff));
	assign pos_next      = (pos_q == slots - SLOT_W'(1)) ? '0 : pos_q + SLOT_W'(1);
	assign last_probe    = (probes_q == slots - SLOT_W'(1));
	assign ins_hit       = (state_q == ST_INS) && !valid_q[pos_q];
	assign out_free      = !out_valid_q || m_axis_tready;

	// Memory write controls: an insert writes the slot and the name together.
	assign slot_we    = ins_hit;
	assign name_we    = ins_hit;
	assign entry_m1   = slot_rdata - IDX_W'(1);
	assign name_raddr = entry_m1[ENTRY_AW-1:0];

	nht_hash u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (hash_start),
		.name   (in_name),
		.slots  (slots),
		.res    (hash_res)
	);

	nht_ram #(
		.WIDTH (IDX_W),
		.DEPTH (SLOT_DEPTH)
	) u_slot_ram (
		.clk   (clk),
		.we    (slot_we),
		.waddr (pos_q),
		.wdata (used_q + IDX_W'(1)),
		.raddr (pos_q),
		.rdata (slot_rdata)
	);

	nht_ram #(
		.WIDTH (NAME_W),
		.DEPTH (MAX_ENTRIES)
	) u_name_ram (
		.clk   (clk),
		.we    (name_we),
		.waddr (used_q[ENTRY_AW-1:0]),
		.wdata (name_q),
		.raddr (name_raddr),
		.rdata (name_rdata)
	);

	// Operation sequencer and table occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cfg_q   <= IDX_W'(MAX_ENTRIES);
			used_q  <= '0;
			valid_q <= '0;
		end else begin
			if (cfg_xfer) begin
				cfg_q   <= cfg_data;
				used_q  <= '0;
				valid_q <= '0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						if (hash_start) begin
							state_q <= ST_HASH;
						end else begin
							state_q <= ST_DONE;
						end
						if (s_axis_tuser == FUNC_CLEAR) begin
							used_q  <= '0;
							valid_q <= '0;
						end
					end
				end
				ST_HASH: begin
					if (hash_res.done) begin
						state_q <= (func_q == FUNC_INSERT) ? ST_INS : ST_LK_SLOT;
					end
				end
				ST_INS: begin
					if (ins_hit) begin
						valid_q[pos_q] <= 1'b1;
						used_q         <= used_q + IDX_W'(1);
						state_q        <= ST_DONE;
					end else if (last_probe) begin
						state_q <= ST_DONE;
					end
				end
				ST_LK_SLOT: begin
					state_q <= ST_LK_NAME;
				end
				ST_LK_NAME: begin
					state_q <= valid_q[pos_q] ? ST_LK_CMP : ST_DONE;
				end
				ST_LK_CMP: begin
					if (name_rdata == name_q || last_probe) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_LK_SLOT;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Per-operation working registers and the pending result.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				func_q    <= s_axis_tuser;
				name_q    <= in_name;
				res_idx_q <= '0;
				if (s_axis_tuser == FUNC_INSERT && used_q >= n_eff) begin
					res_st_q <= STATUS_FULL;
				end else begin
					res_st_q <= STATUS_OK;
				end
			end
			ST_HASH: begin
				pos_q    <= hash_res.pos;
				probes_q <= '0;
			end
			ST_INS: begin
				if (ins_hit) begin
					res_idx_q <= used_q + IDX_W'(1);
					res_st_q  <= STATUS_OK;
				end else begin
					res_st_q <= STATUS_FULL;
					pos_q    <= pos_next;
					probes_q <= probes_q + SLOT_W'(1);
				end
			end
			ST_LK_NAME: begin
				entry_q  <= slot_rdata;
				res_st_q <= STATUS_NOT_FOUND;
			end
			ST_LK_CMP: begin
				if (name_rdata == name_q) begin
					res_idx_q <= entry_q;
					res_st_q  <= STATUS_OK;
				end else begin
					pos_q    <= pos_next;
					probes_q <= probes_q + SLOT_W'(1);
				end
			end
			default: begin
				probes_q <= probes_q;
			end
		endcase
	end

	// Output register: holds a result until its transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_idx_q <= res_idx_q;
			out_st_q  <= res_st_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_DATA_W - IDX_W - STATUS_W){1'b0}}, out_st_q, out_idx_q};

	// The fill count always matches the number of occupied slots.
	a_used_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == 32'(used_q))
		else $error("fill count differs from occupied slot count");

	// The table never holds more entries than the effective count.
	a_used_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= n_eff)
		else $error("fill count above variable count");

	// A probe position always lies inside the active slot range.
	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_INS || state_q == ST_LK_SLOT || state_q == ST_LK_NAME ||
		 state_q == ST_LK_CMP) |-> pos_q < slots)
		else $error("probe position beyond slot count");

	// Only a successful result carries a nonzero index.
	a_idx_only_on_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && out_st_q != STATUS_OK) |-> out_idx_q == '0)
		else $error("failed result carries an entry index");

endmodule

`default_nettype wire

/* hdl/nht_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module nht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

/* hdl/nht_hash.sv */
`timescale 1ns / 1ps
`default_nettype none

module nht_hash import nht_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [NAME_W-1:0] name,
	input  wire logic [SLOT_W-1:0] slots,
	output hash_res_t              res
);

	typedef enum logic [2:0] {
		HS_IDLE = 3'b001,
		HS_HASH = 3'b010,
		HS_MOD  = 3'b100
	} hash_state_t;

	hash_state_t       state_q;
	logic [NAME_W-1:0] name_q;
	logic [2:0]        cnt_q;
	logic [HASH_W-1:0] h_q;
	logic [SLOT_W-1:0] rem_q;
	logic [SLOT_W-1:0] slots_q;
	logic              done_q;

	logic [7:0]        cur_byte;
	logic [31:0]       h_sum;
	logic [31:0]       h_top;
	logic [31:0]       h_next;
	logic [SLOT_W:0]   r_step;
	logic [SLOT_W-1:0] rem_next;

	// One byte of the ELF hash per cycle.
	always_comb begin
		cur_byte = name_q[7:0];
		h_sum    = {h_q, {HASH_SHIFT{1'b0}}} + {24'd0, cur_byte};
		h_top    = h_sum & HASH_TOP_MASK;
		h_next   = h_sum ^ (h_top | (h_top >> HASH_FOLD));
	end

	// Four bits of restoring remainder per cycle; the remainder stays below slots.
	always_comb begin
		r_step = {1'b0, rem_q};
		for (int j = 0; j < HASH_SHIFT; j++) begin
			r_step = {r_step[SLOT_W-1:0], h_q[HASH_W-1-j]};
			if (r_step >= {1'b0, slots_q}) begin
				r_step = r_step - {1'b0, slots_q};
			end
		end
		rem_next = r_step[SLOT_W-1:0];
	end

	// Hash, then reduce modulo the slot count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= HS_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				HS_IDLE: begin
					if (start) begin
						state_q <= HS_HASH;
					end
				end
				HS_HASH: begin
					if (cur_byte == 8'h00 || cnt_q == 3'd7) begin
						state_q <= HS_MOD;
					end
				end
				HS_MOD: begin
					if (cnt_q == 3'(MOD_DIGITS - 1)) begin
						state_q <= HS_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: begin
					state_q <= HS_IDLE;
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			HS_IDLE: begin
				name_q  <= name;
				slots_q <= slots;
				h_q     <= '0;
				rem_q   <= '0;
				cnt_q   <= '0;
			end
			HS_HASH: begin
				if (cur_byte == 8'h00) begin
					cnt_q <= '0;
				end else begin
					h_q    <= h_next[HASH_W-1:0];
					name_q <= name_q >> 8;
					cnt_q  <= cnt_q + 3'd1;
				end
				if (cur_byte != 8'h00 && cnt_q == 3'd7) begin
					cnt_q <= '0;
				end
			end
			HS_MOD: begin
				rem_q <= rem_next;
				h_q   <= h_q << HASH_SHIFT;
				cnt_q <= cnt_q + 3'd1;
			end
			default: begin
				cnt_q <= '0;
			end
		endcase
	end

	assign res.done = done_q;
	assign res.pos  = rem_q;

endmodule

`default_nettype wire
